// ===== sv/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 5;
  localparam int FILL_W  = $clog2(DEPTH + 1);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic  en;
    func_t func;
    key_t  key;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire spq_cmd_t cmd,
  input  wire key_t     left_key,
  input  wire logic     left_valid,
  input  wire logic     left_stay,
  input  wire key_t     right_key,
  input  wire logic     right_valid,
  output key_t          key,
  output logic          valid,
  output logic          stay
);

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;

  // keep this entry in place on insert: it outranks the new key
  assign stay = valid_r && (key_r > cmd.key);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      case (cmd.func)
        FUNC_REMOVE: begin
          key_nxt   = right_key;
          valid_nxt = right_valid;
        end
        FUNC_INSERT: begin
          if (!stay) begin
            key_nxt = left_stay ? cmd.key : left_key;
          end
          valid_nxt = valid_r | left_valid;
        end
        default: begin
          key_nxt   = key_r;
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
// Each input transfer's result is registered directly in the output register.
// Throughput: one insert or remove per cycle unless stalled; every cell compares and shifts in parallel.
// Input is stalled only while the output register holds a result not yet taken.
// Reset (rst_n low, synchronous) empties the queue: cell valid bits and fill clear.
// Stored keys are not reset; a cell is read only once it holds a written key.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // [31:0] key
  input  wire logic        in_tuser,  // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata  // [1:0] status, [33:2] removed_key,
                                      // [65:34] head_key, [70:66] count, [71] zero
);

  key_t              cell_key   [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_stay;
  spq_cmd_t          cmd;

  logic              accept;
  func_t             func;
  key_t              in_key;
  status_t           status;
  key_t              removed;
  key_t              head;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r;
  key_t              removed_r;
  key_t              head_r;
  logic [COUNT_W-1:0] count_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);
  assign in_key    = key_t'(in_tdata);

  always_comb begin
    status   = ST_OK;
    removed  = '0;
    head     = cell_valid[0] ? cell_key[0] : '0;
    fill_nxt = fill_r;
    case (func)
      FUNC_REMOVE: begin
        if (!cell_valid[0]) begin
          status = ST_EMPTY;
        end else begin
          removed  = cell_key[0];
          head     = cell_valid[1] ? cell_key[1] : '0;
          fill_nxt = fill_r - FILL_W'(1);
        end
      end
      FUNC_INSERT: begin
        if (cell_valid[DEPTH-1]) begin
          status = ST_FULL;
        end else begin
          head     = cell_stay[0] ? cell_key[0] : in_key;
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign cmd.en   = accept && (status == ST_OK);
  assign cmd.func = func;
  assign cmd.key  = in_key;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t lk, rk;
    logic lv, ls, rv;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = 1'b1;
      assign ls = 1'b1;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign lv = cell_valid[i-1];
      assign ls = cell_stay[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rv = cell_valid[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_key    (lk),
      .left_valid  (lv),
      .left_stay   (ls),
      .right_key   (rk),
      .right_valid (rv),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .stay        (cell_stay[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status;
      removed_r <= removed;
      head_r    <= head;
      count_r   <= COUNT_W'(fill_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, count_r, head_r, removed_r, status_r};

`ifndef SYNTHESIS
  a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) == $countones(cell_valid))
    else $error("fill count differs from occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_remove_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == FUNC_REMOVE && cell_valid[0]) |=> fill_r == $past(fill_r) - FILL_W'(1))
    else $error("remove did not drop exactly one entry");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status == ST_FULL) |-> 32'(fill_r) == DEPTH)
    else $error("full status with free cells");

  a_head_is_highest: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid[1]) |-> cell_key[0] >= cell_key[1])
    else $error("head key below its successor");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_sorted_priority_queue.sv =====
`default_nettype none

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   RANDOM_ITEMS = 1800;
  localparam key_t KEY_MAX      = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN      = 32'sh8000_0000;

  typedef struct packed {
    status_t              status;
    key_t                 removed;
    key_t                 head;
    logic [COUNT_W-1:0]   count;
  } qresult_t;

  typedef struct {
    func_t    func;
    key_t     key;
    bit       typed;
    qresult_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] key
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [1:0] status, [33:2] removed_key,
                                // [65:34] head_key, [70:66] count, [71] zero

  key_t      sorted_keys [DEPTH];
  int        key_count = 0;
  qresult_t  pending_q [$];
  stim_row_t plan [$];
  qresult_t  seen;
  qresult_t  due;
  int        burst_left = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        stall_mode = 0;
  int        stall_left = 0;

  sorted_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic qresult_t queue_apply(func_t f, key_t k);
    qresult_t r;
    int       pos;
    int       i;
    r = '0;
    r.status = ST_OK;
    if (f == FUNC_REMOVE) begin
      if (key_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed = sorted_keys[0];
        for (i = 1; i < key_count; i++) sorted_keys[i-1] = sorted_keys[i];
        key_count--;
      end
    end else if (key_count >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      if (key_count == 0 || k >= sorted_keys[0]) begin
        pos = 0;
      end else if (k <= sorted_keys[key_count-1]) begin
        pos = key_count;
      end else begin
        pos = 1;
        while (pos < key_count && k < sorted_keys[pos]) pos++;
      end
      for (i = key_count; i > pos; i--) sorted_keys[i] = sorted_keys[i-1];
      sorted_keys[pos] = k;
      key_count++;
    end
    r.head  = (key_count > 0) ? sorted_keys[0] : '0;
    r.count = key_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return key_t'($urandom);
      5, 6:          return key_t'(int'($urandom_range(0, 15)) - 8);
      7: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: begin
        if (key_count > 0) return sorted_keys[$urandom_range(0, key_count - 1)];
        return key_t'($urandom);
      end
    endcase
  endfunction

  task automatic add_row(input func_t f, input key_t k, input bit typed, input status_t s,
                         input key_t rm, input key_t hd, input int cnt);
    stim_row_t row;
    row.func         = f;
    row.key          = k;
    row.typed        = typed;
    row.want.status  = s;
    row.want.removed = rm;
    row.want.head    = hd;
    row.want.count   = cnt[COUNT_W-1:0];
    plan.push_back(row);
  endtask

  task automatic send_item(input func_t f, input key_t k, input bit typed,
                           input qresult_t want);
    qresult_t r;
    int       gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= k;
    do @(posedge clk); while (!in_tready);
    r = queue_apply(f, k);
    pending_q.push_back(typed ? want : r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic field_check(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 0);
      2:       out_tready <= ($urandom_range(0, 9) != 0);
      default: out_tready <= (cycles % 6 == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        due          = pending_q.pop_front();
        seen.status  = status_t'(out_tdata[1:0]);
        seen.removed = out_tdata[33:2];
        seen.head    = out_tdata[65:34];
        seen.count   = out_tdata[70:66];
        field_check("status", due.status, out_tdata[1:0]);
        field_check("removed_key", due.removed, seen.removed);
        field_check("head_key", due.head, seen.head);
        field_check("count", due.count, seen.count);
      end
    end
  end

  initial begin
    func_t f;
    int    insert_pct;
    int    phase_left;
    int    n;
    insert_pct = 50;
    phase_left = 0;

    add_row(FUNC_REMOVE, '0, 1, ST_EMPTY, '0, '0, 0);
    add_row(FUNC_REMOVE, KEY_MAX, 1, ST_EMPTY, '0, '0, 0);
    add_row(FUNC_INSERT, KEY_MAX, 1, ST_OK, '0, KEY_MAX, 1);
    add_row(FUNC_INSERT, KEY_MIN, 1, ST_OK, '0, KEY_MAX, 2);
    add_row(FUNC_INSERT, '0, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, '0, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, KEY_MIN, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, KEY_MAX, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, -1, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 1, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_REMOVE, '0, 1, ST_OK, KEY_MAX, KEY_MAX, 7);
    add_row(FUNC_INSERT, 100, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, -100, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 5, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, -5, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 32'sh4000_0000, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 32'shC000_0000, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 2, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, -2, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 7, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, 3, 1, ST_FULL, '0, KEY_MAX, 16);
    add_row(FUNC_REMOVE, '0, 1, ST_OK, KEY_MAX, 32'sh4000_0000, 15);
    add_row(FUNC_INSERT, KEY_MIN, 0, ST_OK, '0, '0, 0);
    add_row(FUNC_INSERT, KEY_MAX, 1, ST_FULL, '0, 32'sh4000_0000, 16);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_item(plan[i].func, plan[i].key, plan[i].typed, plan[i].want);
    hold_until_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0:       insert_pct = 90;
          1:       insert_pct = 15;
          2:       insert_pct = 50;
          default: insert_pct = 70;
        endcase
      end
      phase_left--;
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      f = ($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
      send_item(f, pick_key(), 1'b0, '0);
    end

    hold_until_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
